### rtl/ppmd_pkg.sv
// ----------------------------------------------------------------------------
// ppmd_pkg
// Shared constants and types of the point to polyline distance unit.
// ----------------------------------------------------------------------------
package ppmd_pkg;

    localparam int COORD_W      = 16;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int DOT_W        = PROD_W + 1;
    localparam int LEN_W        = 2 * COORD_W + 1;
    localparam int DIST_W       = 33;
    localparam int MAX_VERTICES = 1024;
    localparam int IDX_W        = 10;
    localparam int CNT_W        = 11;
    localparam int QCNT_W       = 4;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [DIST_W-1:0] NOT_FOUND_DIST = 33'd8589672450;

    typedef struct packed {
        logic [LEN_W-1:0]   dot;
        logic [LEN_W-1:0]   len2;
        logic [COORD_W-1:0] mag_x;
        logic [COORD_W-1:0] mag_y;
    } div_req_t;

    typedef struct packed {
        logic [COORD_W-1:0] q_x;
        logic [COORD_W-1:0] q_y;
        logic               rem_x_nz;
        logic               rem_y_nz;
    } div_rsp_t;

endpackage

### rtl/ppmd_divider.sv
// ----------------------------------------------------------------------------
// ppmd_divider
// Two-lane bit-serial long division: floor(mag * dot / len2) for both axes.
// ----------------------------------------------------------------------------
module ppmd_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ppmd_pkg::div_req_t req,
    output logic               done,
    output ppmd_pkg::div_rsp_t rsp
);

    typedef struct packed {
        logic [1:0]                 inc;
        logic [ppmd_pkg::LEN_W-1:0] rem;
    } step_t;

    function automatic step_t div_step(input logic [ppmd_pkg::LEN_W-1:0] r,
                                       input logic                       b,
                                       input logic [ppmd_pkg::LEN_W-1:0] t,
                                       input logic [ppmd_pkg::LEN_W-1:0] l);
        logic [ppmd_pkg::LEN_W:0] a;
        step_t                    s;
        a     = {r, 1'b0};
        s.inc = 2'd0;
        if (a >= {1'b0, l})
        begin
            a     = a - {1'b0, l};
            s.inc = 2'd1;
        end
        if (b)
        begin
            a = a + {1'b0, t};
            if (a >= {1'b0, l})
            begin
                a     = a - {1'b0, l};
                s.inc = s.inc + 2'd1;
            end
        end
        s.rem = a[ppmd_pkg::LEN_W-1:0];
        return s;
    endfunction

    logic                          busy_reg,  busy_next;
    logic                          done_reg,  done_next;
    logic [ppmd_pkg::QCNT_W-1:0]   cnt_reg,   cnt_next;
    logic [ppmd_pkg::LEN_W-1:0]    dot_reg,   dot_next;
    logic [ppmd_pkg::LEN_W-1:0]    len_reg,   len_next;
    logic [ppmd_pkg::COORD_W-1:0]  mx_reg,    mx_next;
    logic [ppmd_pkg::COORD_W-1:0]  my_reg,    my_next;
    logic [ppmd_pkg::COORD_W-1:0]  qx_reg,    qx_next;
    logic [ppmd_pkg::COORD_W-1:0]  qy_reg,    qy_next;
    logic [ppmd_pkg::LEN_W-1:0]    rx_reg,    rx_next;
    logic [ppmd_pkg::LEN_W-1:0]    ry_reg,    ry_next;
    step_t                         sx, sy;

    always_comb
    begin
        sx        = div_step(rx_reg, mx_reg[ppmd_pkg::COORD_W-1], dot_reg, len_reg);
        sy        = div_step(ry_reg, my_reg[ppmd_pkg::COORD_W-1], dot_reg, len_reg);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dot_next  = dot_reg;
        len_next  = len_reg;
        mx_next   = mx_reg;
        my_next   = my_reg;
        qx_next   = qx_reg;
        qy_next   = qy_reg;
        rx_next   = rx_reg;
        ry_next   = ry_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dot_next  = req.dot;
            len_next  = req.len2;
            mx_next   = req.mag_x;
            my_next   = req.mag_y;
            qx_next   = '0;
            qy_next   = '0;
            rx_next   = '0;
            ry_next   = '0;
        end
        else if (busy_reg)
        begin
            mx_next  = {mx_reg[ppmd_pkg::COORD_W-2:0], 1'b0};
            my_next  = {my_reg[ppmd_pkg::COORD_W-2:0], 1'b0};
            qx_next  = {qx_reg[ppmd_pkg::COORD_W-2:0], 1'b0}
                       + {{(ppmd_pkg::COORD_W-2){1'b0}}, sx.inc};
            qy_next  = {qy_reg[ppmd_pkg::COORD_W-2:0], 1'b0}
                       + {{(ppmd_pkg::COORD_W-2){1'b0}}, sy.inc};
            rx_next  = sx.rem;
            ry_next  = sy.rem;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {ppmd_pkg::QCNT_W{1'b1}})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dot_reg <= dot_next;
        len_reg <= len_next;
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        qx_reg  <= qx_next;
        qy_reg  <= qy_next;
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
    end

    assign done         = done_reg;
    assign rsp.q_x      = qx_reg;
    assign rsp.q_y      = qy_reg;
    assign rsp.rem_x_nz = (rx_reg != '0);
    assign rsp.rem_y_nz = (ry_reg != '0);

endmodule

### rtl/point_polyline_min_distance_unit.sv
// ----------------------------------------------------------------------------
// point_polyline_min_distance_unit
// Stores a 2D polyline and returns the nearest point on it to a query point.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries command, coord_x, coord_y.
// Clear and append give no result. Append to a full store drops the vertex
// and sets the sticky overflow flag.
// A query walks the segments one at a time. The vertex RAM is read once per
// segment (previous end vertex is kept in a register). Each segment goes
// through load, multiply, sum, classify, square and compare, and the serial
// divider runs between classify and square when the projection falls inside
// the segment. With fewer than two vertices a query goes straight to its result.
// Output channel (out_valid/out_ready) carries one result per query from an
// output register; a new item is taken while that result waits, and a
// finished query holds until the register is free.
// Reset clears the vertex count, the overflow flag and the handshake; the
// RAM contents are not cleared.
// ----------------------------------------------------------------------------
module point_polyline_min_distance_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          command,
    input  logic signed [ppmd_pkg::COORD_W-1:0] coord_x,
    input  logic signed [ppmd_pkg::COORD_W-1:0] coord_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ppmd_pkg::DIST_W-1:0]         sq_distance,
    output logic signed [ppmd_pkg::COORD_W-1:0] nearest_x,
    output logic signed [ppmd_pkg::COORD_W-1:0] nearest_y,
    output logic [ppmd_pkg::IDX_W-1:0]          segment_index,
    output logic                                found,
    output logic                                overflow
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_SUM   = 4'd5;
    localparam logic [3:0] S_CLASS = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_SQ    = 4'd8;
    localparam logic [3:0] S_CMP   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    localparam int CW = ppmd_pkg::COORD_W;
    localparam int DW = ppmd_pkg::DIFF_W;

    logic [2*CW-1:0] mem [ppmd_pkg::MAX_VERTICES];
    logic [2*CW-1:0] rdata_reg;
    logic [ppmd_pkg::IDX_W-1:0] rd_addr;

    logic [3:0]                     state_reg,   state_next;
    logic [ppmd_pkg::CNT_W-1:0]     count_reg,   count_next;
    logic                           ovf_reg,     ovf_next;
    logic [ppmd_pkg::IDX_W-1:0]     seg_reg,     seg_next;
    logic signed [CW-1:0]           px_reg, py_reg;
    logic signed [CW-1:0]           ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [CW-1:0]           cx_reg, cy_reg, cx_next, cy_next;
    logic signed [DW-1:0]           dx_reg, dy_reg;
    logic signed [ppmd_pkg::PROD_W-1:0] pwx_reg, pwy_reg, pdx_reg, pdy_reg;
    logic signed [ppmd_pkg::PROD_W-1:0] ex2_reg, ey2_reg;
    logic signed [ppmd_pkg::DOT_W-1:0]  dot_reg;
    logic [ppmd_pkg::LEN_W-1:0]         len_reg;
    logic [ppmd_pkg::DIST_W-1:0]    best_reg, best_next;
    logic signed [CW-1:0]           nx_reg, ny_reg, nx_next, ny_next;
    logic [ppmd_pkg::IDX_W-1:0]     bi_reg, bi_next;
    logic                           bf_reg, bf_next;

    logic                           out_valid_reg, out_valid_next;
    logic [ppmd_pkg::DIST_W-1:0]    o_dist_reg;
    logic signed [CW-1:0]           o_x_reg, o_y_reg;
    logic [ppmd_pkg::IDX_W-1:0]     o_idx_reg;
    logic                           o_found_reg, o_ovf_reg;
    logic                           o_load;

    logic                           in_xfer, do_append, full;
    logic signed [DW-1:0]           dx_c, dy_c, wx_c, wy_c, ex_c, ey_c;
    logic signed [DW-1:0]           cdx, cdy;
    logic [ppmd_pkg::DIST_W:0]      dist_c;
    logic                           div_start, div_done;
    ppmd_pkg::div_req_t             div_req;
    ppmd_pkg::div_rsp_t             div_rsp;

    ppmd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .done  (div_done),
        .rsp   (div_rsp)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign full      = (count_reg == ppmd_pkg::CNT_W'(ppmd_pkg::MAX_VERTICES));
    assign do_append = in_xfer && (command == ppmd_pkg::CMD_APPEND) && !full;

    assign dx_c = DW'(bx_reg) - DW'(ax_reg);
    assign dy_c = DW'(by_reg) - DW'(ay_reg);
    assign wx_c = DW'(px_reg) - DW'(ax_reg);
    assign wy_c = DW'(py_reg) - DW'(ay_reg);
    assign ex_c = DW'(px_reg) - DW'(cx_reg);
    assign ey_c = DW'(py_reg) - DW'(cy_reg);
    assign dist_c = {1'b0, ex2_reg[ppmd_pkg::DIST_W-1:0]}
                    + {1'b0, ey2_reg[ppmd_pkg::DIST_W-1:0]};

    assign cdx = -dx_reg;
    assign cdy = -dy_reg;
    assign div_req.dot   = dot_reg[ppmd_pkg::LEN_W-1:0];
    assign div_req.len2  = len_reg;
    assign div_req.mag_x = dx_reg[DW-1] ? cdx[CW-1:0] : dx_reg[CW-1:0];
    assign div_req.mag_y = dy_reg[DW-1] ? cdy[CW-1:0] : dy_reg[CW-1:0];

    // vertex RAM: write on append, registered read
    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            mem[count_reg[ppmd_pkg::IDX_W-1:0]] <= {coord_x, coord_y};
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        seg_next   = seg_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        best_next  = best_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        bi_next    = bi_reg;
        bf_next    = bf_reg;
        rd_addr    = '0;
        div_start  = 1'b0;
        o_load     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (command)
                        ppmd_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ppmd_pkg::CMD_APPEND:
                        begin
                            if (full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ppmd_pkg::CMD_QUERY:
                        begin
                            best_next = ppmd_pkg::NOT_FOUND_DIST;
                            nx_next   = '0;
                            ny_next   = '0;
                            bi_next   = '0;
                            bf_next   = 1'b0;
                            seg_next  = '0;
                            state_next = (count_reg < ppmd_pkg::CNT_W'(2)) ? S_DONE : S_RD0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD0:
            begin
                rd_addr    = '0;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                rd_addr    = ppmd_pkg::IDX_W'(1);
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                if (dot_reg[ppmd_pkg::DOT_W-1] || (dot_reg == '0))
                begin
                    cx_next    = ax_reg;
                    cy_next    = ay_reg;
                    state_next = S_SQ;
                end
                else if (dot_reg >= $signed({2'b00, len_reg}))
                begin
                    cx_next    = bx_reg;
                    cy_next    = by_reg;
                    state_next = S_SQ;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    // negative direction: floor rounds away from the start
                    if (dx_reg[DW-1])
                    begin
                        cx_next = ax_reg - CW'(div_rsp.q_x) - CW'(div_rsp.rem_x_nz);
                    end
                    else
                    begin
                        cx_next = ax_reg + CW'(div_rsp.q_x);
                    end
                    if (dy_reg[DW-1])
                    begin
                        cy_next = ay_reg - CW'(div_rsp.q_y) - CW'(div_rsp.rem_y_nz);
                    end
                    else
                    begin
                        cy_next = ay_reg + CW'(div_rsp.q_y);
                    end
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (!bf_reg || (dist_c[ppmd_pkg::DIST_W-1:0] < best_reg))
                begin
                    best_next = dist_c[ppmd_pkg::DIST_W-1:0];
                    nx_next   = cx_reg;
                    ny_next   = cy_reg;
                    bi_next   = seg_reg;
                    bf_next   = 1'b1;
                end
                if ((ppmd_pkg::CNT_W'(seg_reg) + ppmd_pkg::CNT_W'(2)) < count_reg)
                begin
                    rd_addr    = seg_reg + ppmd_pkg::IDX_W'(2);
                    seg_next   = seg_reg + 1'b1;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    o_load     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (o_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg  <= seg_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        best_reg <= best_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        bi_reg   <= bi_next;
        bf_reg   <= bf_next;
        if (in_xfer)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (state_reg == S_RD1)
        begin
            ax_reg <= rdata_reg[2*CW-1:CW];
            ay_reg <= rdata_reg[CW-1:0];
        end
        else if (state_reg == S_CMP)
        begin
            ax_reg <= bx_reg;
            ay_reg <= by_reg;
        end
        if (state_reg == S_LOAD)
        begin
            bx_reg <= rdata_reg[2*CW-1:CW];
            by_reg <= rdata_reg[CW-1:0];
        end
        if (state_reg == S_MUL)
        begin
            dx_reg  <= dx_c;
            dy_reg  <= dy_c;
            pwx_reg <= wx_c * dx_c;
            pwy_reg <= wy_c * dy_c;
            pdx_reg <= dx_c * dx_c;
            pdy_reg <= dy_c * dy_c;
        end
        if (state_reg == S_SUM)
        begin
            dot_reg <= ppmd_pkg::DOT_W'(pwx_reg) + ppmd_pkg::DOT_W'(pwy_reg);
            len_reg <= pdx_reg[ppmd_pkg::LEN_W-1:0] + pdy_reg[ppmd_pkg::LEN_W-1:0];
        end
        if (state_reg == S_SQ)
        begin
            ex2_reg <= ex_c * ex_c;
            ey2_reg <= ey_c * ey_c;
        end
        if (o_load)
        begin
            o_dist_reg  <= best_reg;
            o_x_reg     <= nx_reg;
            o_y_reg     <= ny_reg;
            o_idx_reg   <= bi_reg;
            o_found_reg <= bf_reg;
            o_ovf_reg   <= ovf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sq_distance   = o_dist_reg;
    assign nearest_x     = o_x_reg;
    assign nearest_y     = o_y_reg;
    assign segment_index = o_idx_reg;
    assign found         = o_found_reg;
    assign overflow      = o_ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ppmd_pkg::CNT_W'(ppmd_pkg::MAX_VERTICES))
        else $error("vertex count beyond capacity");

    a_ovf_set: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (command == ppmd_pkg::CMD_APPEND) && full) |=> ovf_reg)
        else $error("dropped append did not set overflow");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_done) |=> (state_reg == S_SQ))
        else $error("divider result not consumed");

    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !o_found_reg) |-> (o_dist_reg == ppmd_pkg::NOT_FOUND_DIST))
        else $error("empty polyline result has wrong distance");

endmodule

### tb/sv/point_polyline_min_distance_unit_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_polyline_min_distance_unit_chk
// Watches both channels of the polyline distance unit, keeps its own copy of
// the polyline, works out the nearest point for every query transfer and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module point_polyline_min_distance_unit_chk (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [1:0]                          command,
    input  logic signed [ppmd_pkg::COORD_W-1:0] coord_x,
    input  logic signed [ppmd_pkg::COORD_W-1:0] coord_y,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [ppmd_pkg::DIST_W-1:0]         sq_distance,
    input  logic signed [ppmd_pkg::COORD_W-1:0] nearest_x,
    input  logic signed [ppmd_pkg::COORD_W-1:0] nearest_y,
    input  logic [ppmd_pkg::IDX_W-1:0]          segment_index,
    input  logic                                found,
    input  logic                                overflow,
    output int                                  errors,
    output int                                  pending
);

    typedef struct packed {
        logic [ppmd_pkg::DIST_W-1:0]  sqd;
        logic [ppmd_pkg::COORD_W-1:0] nx;
        logic [ppmd_pkg::COORD_W-1:0] ny;
        logic [ppmd_pkg::IDX_W-1:0]   seg;
        logic                         hit;
        logic                         ovf;
    } nearest_t;

    longint   vtx_x [ppmd_pkg::MAX_VERTICES];
    longint   vtx_y [ppmd_pkg::MAX_VERTICES];
    int       vtx_count;
    logic     ovf_sticky;
    nearest_t nearest_q[$];

    assign pending = nearest_q.size();

    // floor(d * t / len2), rounded toward minus infinity
    function automatic longint scaled_step(longint d, longint t, longint len2);
        longint n;
        longint q;
        n = d * t;
        q = n / len2;
        if (n % len2 != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic nearest_t nearest_point(longint px, longint py);
        nearest_t r;
        longint   best, ax, ay, dx, dy, t, len2, cx, cy, ex, ey, d2;
        longint   bx, by;
        int       bi;
        logic     hit;
        best = longint'(ppmd_pkg::NOT_FOUND_DIST);
        bx = 0;
        by = 0;
        bi = 0;
        hit = 1'b0;
        for (int i = 0; i + 1 < vtx_count; i++)
        begin
            ax = vtx_x[i];
            ay = vtx_y[i];
            dx = vtx_x[i+1] - ax;
            dy = vtx_y[i+1] - ay;
            t = (px - ax) * dx + (py - ay) * dy;
            len2 = dx * dx + dy * dy;
            if (t <= 0)
            begin
                cx = ax;
                cy = ay;
            end
            else if (t >= len2)
            begin
                cx = ax + dx;
                cy = ay + dy;
            end
            else
            begin
                cx = ax + scaled_step(dx, t, len2);
                cy = ay + scaled_step(dy, t, len2);
            end
            ex = px - cx;
            ey = py - cy;
            d2 = ex * ex + ey * ey;
            if (!hit || d2 < best)
            begin
                best = d2;
                bx = cx;
                by = cy;
                bi = i;
                hit = 1'b1;
            end
        end
        r.sqd  = best[ppmd_pkg::DIST_W-1:0];
        r.nx   = bx[ppmd_pkg::COORD_W-1:0];
        r.ny   = by[ppmd_pkg::COORD_W-1:0];
        r.seg  = bi[ppmd_pkg::IDX_W-1:0];
        r.hit  = hit;
        r.ovf  = ovf_sticky;
        return r;
    endfunction

    task automatic report(string field, longint want, longint got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
    endtask

    initial
    begin
        errors = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        nearest_t want;
        if (!rst_n)
        begin
            vtx_count  = 0;
            ovf_sticky = 1'b0;
            nearest_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (nearest_q.size() == 0)
                begin
                    $display("%0t: result transfer with no query waiting", $time);
                    errors++;
                end
                else
                begin
                    want = nearest_q.pop_front();
                    if (sq_distance !== want.sqd)
                        report("sq_distance", want.sqd, sq_distance);
                    if (nearest_x !== want.nx)
                        report("nearest_x", $signed(want.nx), nearest_x);
                    if (nearest_y !== want.ny)
                        report("nearest_y", $signed(want.ny), nearest_y);
                    if (segment_index !== want.seg)
                        report("segment_index", want.seg, segment_index);
                    if (found !== want.hit)
                        report("found", want.hit, found);
                    if (overflow !== want.ovf)
                        report("overflow", want.ovf, overflow);
                end
            end
            if (in_valid && in_ready)
            begin
                case (command)
                    ppmd_pkg::CMD_CLEAR:
                        vtx_count = 0;
                    ppmd_pkg::CMD_APPEND:
                        if (vtx_count < ppmd_pkg::MAX_VERTICES)
                        begin
                            vtx_x[vtx_count] = coord_x;
                            vtx_y[vtx_count] = coord_y;
                            vtx_count++;
                        end
                        else
                            ovf_sticky = 1'b1;
                    ppmd_pkg::CMD_QUERY:
                        nearest_q = {nearest_q, nearest_point(coord_x, coord_y)};
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/sv/point_polyline_min_distance_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_polyline_min_distance_unit_tb
// Drives clear, append and query transfers into the polyline distance unit:
// a directed opening over extremes and corner cases, then random polylines
// with queries under three idle patterns.
// ----------------------------------------------------------------------------
module point_polyline_min_distance_unit_tb;

    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic [1:0]                          command = ppmd_pkg::CMD_CLEAR;
    logic signed [ppmd_pkg::COORD_W-1:0] coord_x = '0;
    logic signed [ppmd_pkg::COORD_W-1:0] coord_y = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [ppmd_pkg::DIST_W-1:0]         sq_distance;
    logic signed [ppmd_pkg::COORD_W-1:0] nearest_x;
    logic signed [ppmd_pkg::COORD_W-1:0] nearest_y;
    logic [ppmd_pkg::IDX_W-1:0]          segment_index;
    logic                                found;
    logic                                overflow;
    int                                  errors;
    int                                  pending;
    int                                  tx_idle_pct = 0;
    int                                  rx_idle_pct = 0;
    int                                  cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    point_polyline_min_distance_unit uut (.*);
    point_polyline_min_distance_unit_chk chk (.*);

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("point_polyline_min_distance_unit_tb: done, errors");
            $finish;
        end
    end

    task automatic send(logic [1:0] cmd, int x, int y);
        in_valid <= 1'b1;
        command  <= cmd;
        coord_x  <= x[ppmd_pkg::COORD_W-1:0];
        coord_y  <= y[ppmd_pkg::COORD_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic int rand_coord(int span);
        if (span == 0)
            return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // clear (not always), a random polyline, then a few queries; sometimes broken or noisy
    task automatic random_polyline();
        int nv, span, cx, cy;
        span = ($urandom_range(3) == 0) ? 0 : ($urandom_range(1) ? 40 : 2000);
        nv = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 9);
        cx = rand_coord(span);
        cy = rand_coord(span);
        if ($urandom_range(7) != 0)
            send(ppmd_pkg::CMD_CLEAR, rand_coord(0), rand_coord(0));
        for (int i = 0; i < nv; i++)
        begin
            // repeated vertex now and then for zero-length segments
            if ($urandom_range(7) != 0)
            begin
                cx = rand_coord(span);
                cy = rand_coord(span);
            end
            send(ppmd_pkg::CMD_APPEND, cx, cy);
        end
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(9) == 0)
                send(CMD_UNUSED, rand_coord(0), rand_coord(0));
            send(ppmd_pkg::CMD_QUERY, rand_coord(span), rand_coord(span));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty, single vertex, extremes, zero length, tie, unused code
        send(ppmd_pkg::CMD_QUERY, 5, -5);
        send(ppmd_pkg::CMD_APPEND, -32768, -32768);
        send(ppmd_pkg::CMD_QUERY, 32767, 32767);
        send(ppmd_pkg::CMD_APPEND, 32767, 32767);
        send(ppmd_pkg::CMD_QUERY, -32768, 32767);
        send(ppmd_pkg::CMD_QUERY, 32767, -32768);
        send(ppmd_pkg::CMD_QUERY, -32768, -32768);
        send(ppmd_pkg::CMD_APPEND, 32767, 32767);
        send(ppmd_pkg::CMD_APPEND, 32767, -32768);
        send(ppmd_pkg::CMD_QUERY, 32767, 32767);
        send(ppmd_pkg::CMD_QUERY, -1, 0);
        send(ppmd_pkg::CMD_CLEAR, 0, 0);
        send(ppmd_pkg::CMD_APPEND, -10, 0);
        send(ppmd_pkg::CMD_APPEND, 0, 10);
        send(ppmd_pkg::CMD_APPEND, 10, 0);
        send(ppmd_pkg::CMD_QUERY, 0, 0);
        send(ppmd_pkg::CMD_QUERY, 3, 4);
        send(CMD_UNUSED, 100, 100);
        send(ppmd_pkg::CMD_QUERY, -7, 1);
        send(ppmd_pkg::CMD_CLEAR, -1, -1);
        send(ppmd_pkg::CMD_QUERY, 0, 0);

        tx_idle_pct = 37;
        rx_idle_pct = 83;
        repeat (22) random_polyline();

        // hold off until the unit has drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        tx_idle_pct = 83;
        rx_idle_pct = 37;
        repeat (22) random_polyline();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (16) random_polyline();

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("point_polyline_min_distance_unit_tb: done, clean");
        else
            $display("point_polyline_min_distance_unit_tb: done, errors");
        $finish;
    end

endmodule

### sim.f
rtl/ppmd_pkg.sv
rtl/ppmd_divider.sv
rtl/point_polyline_min_distance_unit.sv
tb/sv/point_polyline_min_distance_unit_chk.sv
tb/sv/point_polyline_min_distance_unit_tb.sv
